>>> rtl/sdi_pkg.sv
package sdi_pkg;

  // command indexes
  localparam logic [5:0] CMD_GO_IDLE     = 6'd0;
  localparam logic [5:0] CMD_ALL_SEND_CID = 6'd2;
  localparam logic [5:0] CMD_SEND_RCA    = 6'd3;
  localparam logic [5:0] CMD_IF_COND     = 6'd8;
  localparam logic [5:0] CMD_VOLT_SWITCH = 6'd11;
  localparam logic [5:0] ACMD_SD_OP_COND = 6'd41;
  localparam logic [5:0] CMD_APP_CMD     = 6'd55;

  // expected reply kinds
  localparam logic [2:0] RK_R1 = 3'd0;
  localparam logic [2:0] RK_R2 = 3'd1;
  localparam logic [2:0] RK_R3 = 3'd2;
  localparam logic [2:0] RK_R6 = 3'd3;
  localparam logic [2:0] RK_R7 = 3'd4;

  // card kinds
  localparam logic [1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [1:0] KIND_V1      = 2'd1;
  localparam logic [1:0] KIND_V2SC    = 2'd2;
  localparam logic [1:0] KIND_V2HC    = 2'd3;

  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_NO_RESPONSE = 4'd1;

  localparam logic [23:0] WINDOW_RESET = 24'hff8000;

  // configuration register indexes
  localparam logic [1:0] REG_PCIE_LOW_VOLT = 2'd0;
  localparam logic [1:0] REG_PCIE_AVAIL    = 2'd1;
  localparam logic [1:0] REG_SUPPLY_VOLT   = 2'd2;
  localparam logic [1:0] REG_CHECK_PATTERN = 2'd3;

  typedef struct packed {
    logic       pcie_low_volt_support;
    logic       pcie_available;
    logic [3:0] supply_voltage_code;
    logic [7:0] check_pattern;
  } sdi_cfg_t;

endpackage

>>> rtl/sdi_cfg.sv
module sdi_cfg (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic [1:0]      wr_index,
  input  logic [7:0]      wr_data,
  output sdi_pkg::sdi_cfg_t cfg
);
  import sdi_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pcie_low_volt_support <= 1'b0;
      cfg.pcie_available        <= 1'b0;
      cfg.supply_voltage_code   <= 4'd1;
      cfg.check_pattern         <= 8'h55;
    end else if (wr_en) begin
      case (wr_index)
        REG_PCIE_LOW_VOLT: cfg.pcie_low_volt_support <= wr_data[0];
        REG_PCIE_AVAIL:    cfg.pcie_available        <= wr_data[0];
        REG_SUPPLY_VOLT:   cfg.supply_voltage_code   <= wr_data[3:0];
        REG_CHECK_PATTERN: cfg.check_pattern         <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/sdi_seq.sv
module sdi_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              req_ready,
  input  logic              resp_valid,
  input  logic [31:0]       resp_arg,
  input  logic [3:0]        cmd_error,
  input  sdi_pkg::sdi_cfg_t cfg,
  output logic              cmd_valid,
  output logic [5:0]        cmd_index,
  output logic [31:0]       cmd_arg,
  output logic [2:0]        resp_kind,
  output logic              clear_status,
  output logic              slow_clock_enable,
  output logic [1:0]        card_kind,
  output logic [15:0]       card_address
);
  import sdi_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_READY = 4'd1,
    PH_IDENT = 4'd2,
    PH_STBY  = 4'd3
  } phase_t;

  typedef enum logic [2:0] {
    IS_CMD0   = 3'd0,
    IS_CMD8   = 3'd1,
    IS_CMD55  = 3'd2,
    IS_ACMD41 = 3'd3,
    IS_CHECK  = 3'd5
  } idle_step_t;

  typedef enum logic [1:0] {
    RS_CMD11 = 2'd0,
    RS_CMD2  = 2'd1,
    RS_CHECK = 2'd2
  } ready_step_t;

  typedef enum logic {
    NS_CMD3  = 1'b0,
    NS_CHECK = 1'b1
  } ident_step_t;

  phase_t      card_phase, card_phase_next;
  idle_step_t  idle_step, idle_step_next;
  ready_step_t ready_step, ready_step_next;
  ident_step_t ident_step, ident_step_next;
  logic        request_pending, request_pending_next;
  logic        awaiting_reply, awaiting_reply_next;
  logic [5:0]  pending_index, pending_index_next;
  logic [31:0] pending_arg, pending_arg_next;
  logic [2:0]  pending_resp_kind, pending_resp_kind_next;
  logic        last_reply_busy_n, last_reply_busy_n_next;
  logic [1:0]  card_type_reg, card_type_reg_next;
  logic        high_capacity, high_capacity_next;
  logic        low_voltage_req, low_voltage_req_next;
  logic [23:0] voltage_window, voltage_window_next;
  logic [15:0] relative_address, relative_address_next;
  logic        slow_clock, slow_clock_next;
  logic        err_pulse, err_pulse_next;
  logic [31:0] if_cond_arg;
  logic [31:0] op_cond_arg;

  assign if_cond_arg = {18'd0, cfg.pcie_low_volt_support, cfg.pcie_available,
                        cfg.supply_voltage_code, cfg.check_pattern};
  assign op_cond_arg = {1'b0, high_capacity, 5'd0, low_voltage_req, voltage_window};

  always_comb begin
    card_phase_next        = card_phase;
    idle_step_next         = idle_step;
    ready_step_next        = ready_step;
    ident_step_next        = ident_step;
    request_pending_next   = request_pending;
    awaiting_reply_next    = awaiting_reply;
    pending_index_next     = pending_index;
    pending_arg_next       = pending_arg;
    pending_resp_kind_next = pending_resp_kind;
    last_reply_busy_n_next = last_reply_busy_n;
    card_type_reg_next     = card_type_reg;
    high_capacity_next     = high_capacity;
    low_voltage_req_next   = low_voltage_req;
    voltage_window_next    = voltage_window;
    relative_address_next  = relative_address;
    slow_clock_next        = slow_clock;
    err_pulse_next         = 1'b0;

    if (request_pending) begin
      if (req_ready) begin
        request_pending_next = 1'b0;
        awaiting_reply_next  = 1'b1;
      end
    end else if (resp_valid && awaiting_reply) begin
      awaiting_reply_next    = 1'b0;
      last_reply_busy_n_next = resp_arg[31];
      if (pending_resp_kind == RK_R3) begin
        if (resp_arg[31]) begin
          voltage_window_next  = resp_arg[23:0];
          high_capacity_next   = resp_arg[30];
          low_voltage_req_next = resp_arg[24];
          if (resp_arg[30]) begin
            card_type_reg_next = KIND_V2HC;
          end else if (card_type_reg == KIND_UNKNOWN) begin
            card_type_reg_next = KIND_V2SC;
          end
        end
      end else if (pending_resp_kind == RK_R6) begin
        relative_address_next = resp_arg[31:16];
      end
    end else if (awaiting_reply) begin
      // hold until the reply shows up
    end else begin
      case (card_phase)
        PH_IDLE: begin
          slow_clock_next = 1'b1;
          case (idle_step)
            IS_CMD0: begin
              card_type_reg_next     = KIND_UNKNOWN;
              high_capacity_next     = 1'b1;
              low_voltage_req_next   = 1'b0;
              relative_address_next  = 16'd0;
              request_pending_next   = 1'b1;
              pending_index_next     = CMD_GO_IDLE;
              pending_resp_kind_next = RK_R1;
              pending_arg_next       = 32'd0;
              idle_step_next         = IS_CMD8;
            end
            IS_CMD8: begin
              // an error left by cmd0 skips the request but the fields still load
              request_pending_next   = (cmd_error == ERR_NONE);
              err_pulse_next         = (cmd_error != ERR_NONE);
              pending_index_next     = CMD_IF_COND;
              pending_resp_kind_next = RK_R7;
              pending_arg_next       = if_cond_arg;
              idle_step_next         = IS_CMD55;
            end
            IS_CMD55: begin
              // no reply to cmd8 means a version 1.x card
              if (cmd_error == ERR_NO_RESPONSE) begin
                card_type_reg_next = KIND_V1;
                high_capacity_next = 1'b0;
                err_pulse_next     = 1'b1;
              end
              request_pending_next   = 1'b1;
              pending_index_next     = CMD_APP_CMD;
              pending_resp_kind_next = RK_R1;
              pending_arg_next       = 32'd0;
              idle_step_next         = IS_ACMD41;
            end
            IS_ACMD41: begin
              request_pending_next   = 1'b1;
              pending_index_next     = ACMD_SD_OP_COND;
              pending_resp_kind_next = RK_R3;
              pending_arg_next       = op_cond_arg;
              idle_step_next         = IS_CHECK;
            end
            IS_CHECK: begin
              if (!last_reply_busy_n) begin
                idle_step_next = IS_CMD55;
              end else begin
                ready_step_next = low_voltage_req ? RS_CMD11 : RS_CMD2;
                card_phase_next = PH_READY;
              end
            end
            default: begin
              idle_step_next = IS_CMD0;
            end
          endcase
        end
        PH_READY: begin
          case (ready_step)
            RS_CMD11: begin
              request_pending_next   = 1'b1;
              pending_index_next     = CMD_VOLT_SWITCH;
              pending_resp_kind_next = RK_R1;
              pending_arg_next       = 32'd0;
              ready_step_next        = RS_CMD2;
            end
            RS_CMD2: begin
              request_pending_next   = 1'b1;
              pending_index_next     = CMD_ALL_SEND_CID;
              pending_resp_kind_next = RK_R2;
              pending_arg_next       = 32'd0;
              ready_step_next        = RS_CHECK;
            end
            RS_CHECK: begin
              card_phase_next = PH_IDENT;
              ident_step_next = NS_CMD3;
            end
            default: ;
          endcase
        end
        PH_IDENT: begin
          if (ident_step == NS_CMD3) begin
            request_pending_next   = 1'b1;
            pending_index_next     = CMD_SEND_RCA;
            pending_resp_kind_next = RK_R6;
            pending_arg_next       = 32'd0;
            ident_step_next        = NS_CHECK;
          end else begin
            card_phase_next = PH_STBY;
            slow_clock_next = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      card_phase        <= PH_IDLE;
      idle_step         <= IS_CMD0;
      ready_step        <= RS_CMD11;
      ident_step        <= NS_CMD3;
      request_pending   <= 1'b0;
      awaiting_reply    <= 1'b0;
      pending_index     <= 6'd0;
      pending_arg       <= 32'd0;
      pending_resp_kind <= RK_R1;
      last_reply_busy_n <= 1'b0;
      card_type_reg     <= KIND_UNKNOWN;
      high_capacity     <= 1'b1;
      low_voltage_req   <= 1'b0;
      voltage_window    <= WINDOW_RESET;
      relative_address  <= 16'd0;
      slow_clock        <= 1'b1;
      err_pulse         <= 1'b0;
    end else if (step) begin
      card_phase        <= card_phase_next;
      idle_step         <= idle_step_next;
      ready_step        <= ready_step_next;
      ident_step        <= ident_step_next;
      request_pending   <= request_pending_next;
      awaiting_reply    <= awaiting_reply_next;
      pending_index     <= pending_index_next;
      pending_arg       <= pending_arg_next;
      pending_resp_kind <= pending_resp_kind_next;
      last_reply_busy_n <= last_reply_busy_n_next;
      card_type_reg     <= card_type_reg_next;
      high_capacity     <= high_capacity_next;
      low_voltage_req   <= low_voltage_req_next;
      voltage_window    <= voltage_window_next;
      relative_address  <= relative_address_next;
      slow_clock        <= slow_clock_next;
      err_pulse         <= err_pulse_next;
    end
  end

  assign cmd_valid         = request_pending;
  assign cmd_index         = pending_index;
  assign cmd_arg           = pending_arg;
  assign resp_kind         = pending_resp_kind;
  assign clear_status      = err_pulse;
  assign slow_clock_enable = slow_clock;
  assign card_kind         = card_type_reg;
  assign card_address      = relative_address;

endmodule

>>> rtl/sd_card_init_sequencer.sv
// sd-mode card initialization sequencer
//
// each input item is one controller cycle as seen by the sequencer: the
// sender's req_ready, a reply strobe with its 32-bit argument, and the
// current error code. each item produces exactly one result item: the
// command request (cmd_valid/cmd_index/cmd_arg/resp_kind), the clear_status
// pulse, the slow clock enable, the card kind and the relative address
// as they stand after that cycle.
// the result of an item is registered and shown in the cycle after it is accepted.
// throughput: one item per cycle; the sequencer state itself is the result
// register, so a new item is taken whenever the output is empty or its
// item is taken in the same cycle.
// when the receiver stalls, the shown item holds and in_stall rises, so no
// further item enters until the result is taken.
// configuration: cfg_valid/cfg_ready with a 2-bit register index and 8-bit
// data, always ready; write only while the sequencer is idle.
// reset (rst, synchronous) puts the sequence back at the cmd0 step, clears
// the card info and reloads the configuration defaults.
module sd_card_init_sequencer (
  input  logic        clk,
  input  logic        rst,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_ready,
  input  logic        resp_valid,
  input  logic [31:0] resp_arg,
  input  logic [3:0]  cmd_error,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic        cmd_valid,
  output logic [5:0]  cmd_index,
  output logic [31:0] cmd_arg,
  output logic [2:0]  resp_kind,
  output logic        clear_status,
  output logic        slow_clock_enable,
  output logic [1:0]  card_kind,
  output logic [15:0] card_address
);
  import sdi_pkg::*;

  sdi_cfg_t cfg;
  logic     in_take;
  logic     out_take;

  // config registers never stall
  assign cfg_ready = 1'b1;

  sdi_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // the output holds while stalled, so the state may only move when the
  // result slot is free or being emptied this cycle
  assign in_stall = out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer state doubles as the result register
  sdi_seq u_seq (
    .clk               (clk),
    .rst               (rst),
    .step              (in_take),
    .req_ready         (req_ready),
    .resp_valid        (resp_valid),
    .resp_arg          (resp_arg),
    .cmd_error         (cmd_error),
    .cfg               (cfg),
    .cmd_valid         (cmd_valid),
    .cmd_index         (cmd_index),
    .cmd_arg           (cmd_arg),
    .resp_kind         (resp_kind),
    .clear_status      (clear_status),
    .slow_clock_enable (slow_clock_enable),
    .card_kind         (card_kind),
    .card_address      (card_address)
  );

endmodule

>>> rtl/sdi_checker.sv
module sdi_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  cmd_index,
  input logic [31:0] cmd_arg,
  input logic        clear_status,
  input logic        slow_clock_enable,
  input logic [1:0]  card_kind
);
  import sdi_pkg::*;

  // a stalled result is kept
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cmd_index) && $stable(cmd_arg))
    else $error("stalled result changed");

  // a full, stalled output slot blocks the input side
  a_in_blocked: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result slot is stalled");

  // error clear only comes with the cmd8 or cmd55 step
  a_err_clear_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && clear_status |-> (cmd_index == CMD_IF_COND) || (cmd_index == CMD_APP_CMD))
    else $error("error clear outside cmd8/cmd55 step");

  // standby is only reached with a classified card
  a_stby_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && !slow_clock_enable |-> card_kind != KIND_UNKNOWN)
    else $error("standby with unknown card kind");

endmodule

bind sd_card_init_sequencer sdi_checker u_sdi_checker (
  .clk               (clk),
  .rst               (rst),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .cmd_index         (cmd_index),
  .cmd_arg           (cmd_arg),
  .clear_status      (clear_status),
  .slow_clock_enable (slow_clock_enable),
  .card_kind         (card_kind)
);
